>>> rtl/lpfb_pkg.sv
// ----------------------------------------------------------------------------
// lpfb_pkg: shared types for the LRU page frame buffer
// Field widths of the request and result words and the control-to-datapath
// command struct.
// ----------------------------------------------------------------------------
package lpfb_pkg;

    localparam int PAGE_W  = 31;
    localparam int FRAME_W = 4;

    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [FRAME_W-1:0] t_frame;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;  // latch the request word
        logic lookup;   // compare tags, pick the frame
        logic commit;   // update frames, load the result word
    } t_dp_cmd;

endpackage

>>> rtl/lru_page_frame_buffer.sv
// ----------------------------------------------------------------------------
// lru_page_frame_buffer: fully associative LRU buffer pool of page frames
// Looks up a disk page among FRAMES frames and reports the frame, hit, and
// any page replaced under least recently used order.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_ready) carries one word: i_disk_page.
//   Result channel (o_out_valid / i_out_ready) returns one word per request:
//   o_frame (low 4 bits of the frame index), o_hit, o_evicted, and
//   o_evicted_page (zero unless a resident page was replaced).
//   An accepted request is captured, then passes the lookup and update
//   states; the update loads its result once the result register is free.
//   Each request takes a lookup step (parallel tag compare over all frames,
//   free/LRU frame select, victim tag RAM read) and an update step (rank
//   aging, tag write, result load). The next request is taken in the update
//   step when the result register is free to load.
//   Stall: if the result word is not taken, the update waits for the result
//   register and the request channel holds off ready; nothing is dropped.
//   Reset (i_rst_n low, synchronous): all frames empty, ranks zero, both
//   channels idle. No clearing pass is needed; valid bits clear at once.
// ----------------------------------------------------------------------------
module lru_page_frame_buffer #(
    parameter int FRAMES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lpfb_pkg::t_page     i_disk_page,
    // result
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lpfb_pkg::t_frame    o_frame,
    output logic                o_hit,
    output logic                o_evicted,
    output lpfb_pkg::t_page     o_evicted_page
);

    lpfb_pkg::t_dp_cmd cmd;

    // sequencer: idle -> lookup -> update
    lpfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // frame table, LRU ranks, result word
    lpfb_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_disk_page    (i_disk_page),
        .o_frame        (o_frame),
        .o_hit          (o_hit),
        .o_evicted      (o_evicted),
        .o_evicted_page (o_evicted_page)
    );

endmodule

>>> rtl/lpfb_ram.sv
// ----------------------------------------------------------------------------
// lpfb_ram: generic simple dual port RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module lpfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lpfb_ctrl.sv
// ----------------------------------------------------------------------------
// lpfb_ctrl: request sequencer
// Steps each request word through lookup and update, and owns the result
// word's valid flag.
// ----------------------------------------------------------------------------
module lpfb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lpfb_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_load;
    logic   accept;

    // result register is free this cycle
    assign can_load   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_UPD) && can_load);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_state     = accept ? S_LOOK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = accept;
    assign o_cmd.lookup  = (r_state == S_LOOK);
    assign o_cmd.commit  = (r_state == S_UPD) && can_load;

endmodule

>>> rtl/lpfb_dp.sv
// ----------------------------------------------------------------------------
// lpfb_dp: frame table datapath
// Tag/valid/rank lanes with parallel compare, LRU rank aging, a tag RAM copy
// for reading the victim page, and the result word registers.
// ----------------------------------------------------------------------------
module lpfb_dp #(
    parameter int FRAMES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpfb_pkg::t_dp_cmd   i_cmd,
    input  lpfb_pkg::t_page     i_disk_page,
    output lpfb_pkg::t_frame    o_frame,
    output logic                o_hit,
    output logic                o_evicted,
    output lpfb_pkg::t_page     o_evicted_page
);

    localparam int IW = $clog2(FRAMES);

    typedef logic [IW-1:0] t_idx;

    lpfb_pkg::t_page r_page;
    lpfb_pkg::t_page r_tag [FRAMES];
    logic [FRAMES-1:0] r_valid;
    t_idx            r_rank [FRAMES];

    t_idx            r_frame;
    t_idx            r_limit;
    logic            r_hit;
    logic            r_evict;

    lpfb_pkg::t_frame r_o_frame;
    logic             r_o_hit;
    logic             r_o_evicted;
    lpfb_pkg::t_page  r_o_evicted_page;

    logic [FRAMES-1:0] match;
    logic [FRAMES-1:0] victim;
    logic              hit_any;
    logic              full;
    t_idx              hit_idx;
    t_idx              free_idx;
    t_idx              vic_idx;
    t_idx              sel_idx;
    t_idx              ram_raddr;
    lpfb_pkg::t_page   ram_rdata;

    // parallel tag compare; oldest frame holds rank FRAMES-1 when full
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            match[i]  = r_valid[i] && (r_tag[i] == r_page);
            victim[i] = r_valid[i] && (r_rank[i] == t_idx'(FRAMES - 1));
        end
    end

    assign hit_any = |match;
    assign full    = &r_valid;

    // lowest-index encoders
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        vic_idx  = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = t_idx'(i);
            end
            if (!r_valid[i]) begin
                free_idx = t_idx'(i);
            end
            if (victim[i]) begin
                vic_idx = t_idx'(i);
            end
        end
    end

    always_comb begin
        priority if (hit_any) begin
            sel_idx = hit_idx;
        end else if (!full) begin
            sel_idx = free_idx;
        end else begin
            sel_idx = vic_idx;
        end
    end

    // victim page read: address from lookup, then held through the update
    assign ram_raddr = i_cmd.lookup ? sel_idx : r_frame;

    lpfb_ram #(
        .WIDTH (lpfb_pkg::PAGE_W),
        .DEPTH (FRAMES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && !r_hit),
        .i_waddr (r_frame),
        .i_wdata (r_page),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // valid and recency state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            for (int i = 0; i < FRAMES; i++) begin
                if (t_idx'(i) == r_frame) begin
                    r_valid[i] <= 1'b1;
                    r_rank[i]  <= '0;
                end else if (r_valid[i] && (!r_hit || (r_rank[i] < r_limit))) begin
                    r_rank[i] <= r_rank[i] + t_idx'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_page <= i_disk_page;
        end
        if (i_cmd.lookup) begin
            r_frame <= sel_idx;
            r_hit   <= hit_any;
            r_evict <= !hit_any && full;
            r_limit <= r_rank[hit_idx];
        end
        if (i_cmd.commit) begin
            r_tag[r_frame]   <= r_page;
            r_o_frame        <= lpfb_pkg::t_frame'(r_frame);
            r_o_hit          <= r_hit;
            r_o_evicted      <= r_evict;
            r_o_evicted_page <= r_evict ? ram_rdata : '0;
        end
    end

    assign o_frame        = r_o_frame;
    assign o_hit          = r_o_hit;
    assign o_evicted      = r_o_evicted;
    assign o_evicted_page = r_o_evicted_page;

`ifndef ASSERT_OFF
    a_one_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.lookup && full) |-> $onehot(victim))
        else $error("ranks not distinct in a full table");

    a_unique_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lookup |-> $onehot0(match))
        else $error("page resident in more than one frame");

    a_commit_mru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_valid[r_frame] && (r_rank[r_frame] == '0)))
        else $error("committed frame not valid and most recent");

    a_valid_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) >= $countones($past(r_valid)))
        else $error("frame lost its valid bit");
`endif

endmodule
